/* sv/aes_block_cipher_with_key_expansion_defines.svh */
// Assertion macros shared by the cipher RTL.
`ifndef AES_BLOCK_CIPHER_WITH_KEY_EXPANSION_DEFINES_SVH
`define AES_BLOCK_CIPHER_WITH_KEY_EXPANSION_DEFINES_SVH

// Plain property check on the rising clock edge, off during reset.
`define AES_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication check.
`define AES_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication check.
`define AES_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/aes_pkg.sv */
// Shared types, S-box tables and GF(2^8) helpers for the AES cipher.
`timescale 1ns / 1ps
`default_nettype none
package aes_pkg;

  localparam int unsigned WORD_IDX_W = 6;
  localparam logic [7:0] GF_POLY   = 8'h1b;
  localparam logic [7:0] RCON_INIT = 8'h01;

  localparam logic [1:0] KEY_SIZE_128 = 2'd0;
  localparam logic [1:0] KEY_SIZE_192 = 2'd1;
  localparam logic [1:0] KEY_SIZE_256 = 2'd2;

  localparam logic [2:0] REG_KEY_SIZE  = 3'd0;
  localparam logic [2:0] REG_DIRECTION = 3'd1;
  localparam logic [2:0] REG_KEY_WORD0 = 3'd2;
  localparam logic [2:0] REG_KEY_WORD3 = 3'd5;

  typedef struct packed {
    logic [63:0] block_high;
    logic [63:0] block_low;
  } in_item_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
  } out_item_t;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_FULL,
    OP_LAST
  } round_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXPAND,
    ST_FETCH,
    ST_ROUND,
    ST_DONE
  } seq_state_e;

  typedef struct packed {
    logic [3:0]   nk;
    logic [3:0]   nr;
    logic [5:0]   total;
    logic         enc;
    logic [255:0] key;
  } kexp_cfg_t;

  typedef struct packed {
    logic                  en;
    logic                  last;
    logic [WORD_IDX_W-1:0] idx;
    logic [31:0]           data;
  } kexp_wr_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52, 8'h09, 8'h6a, 8'hd5, 8'h30, 8'h36, 8'ha5, 8'h38,
    8'hbf, 8'h40, 8'ha3, 8'h9e, 8'h81, 8'hf3, 8'hd7, 8'hfb,
    8'h7c, 8'he3, 8'h39, 8'h82, 8'h9b, 8'h2f, 8'hff, 8'h87,
    8'h34, 8'h8e, 8'h43, 8'h44, 8'hc4, 8'hde, 8'he9, 8'hcb,
    8'h54, 8'h7b, 8'h94, 8'h32, 8'ha6, 8'hc2, 8'h23, 8'h3d,
    8'hee, 8'h4c, 8'h95, 8'h0b, 8'h42, 8'hfa, 8'hc3, 8'h4e,
    8'h08, 8'h2e, 8'ha1, 8'h66, 8'h28, 8'hd9, 8'h24, 8'hb2,
    8'h76, 8'h5b, 8'ha2, 8'h49, 8'h6d, 8'h8b, 8'hd1, 8'h25,
    8'h72, 8'hf8, 8'hf6, 8'h64, 8'h86, 8'h68, 8'h98, 8'h16,
    8'hd4, 8'ha4, 8'h5c, 8'hcc, 8'h5d, 8'h65, 8'hb6, 8'h92,
    8'h6c, 8'h70, 8'h48, 8'h50, 8'hfd, 8'hed, 8'hb9, 8'hda,
    8'h5e, 8'h15, 8'h46, 8'h57, 8'ha7, 8'h8d, 8'h9d, 8'h84,
    8'h90, 8'hd8, 8'hab, 8'h00, 8'h8c, 8'hbc, 8'hd3, 8'h0a,
    8'hf7, 8'he4, 8'h58, 8'h05, 8'hb8, 8'hb3, 8'h45, 8'h06,
    8'hd0, 8'h2c, 8'h1e, 8'h8f, 8'hca, 8'h3f, 8'h0f, 8'h02,
    8'hc1, 8'haf, 8'hbd, 8'h03, 8'h01, 8'h13, 8'h8a, 8'h6b,
    8'h3a, 8'h91, 8'h11, 8'h41, 8'h4f, 8'h67, 8'hdc, 8'hea,
    8'h97, 8'hf2, 8'hcf, 8'hce, 8'hf0, 8'hb4, 8'he6, 8'h73,
    8'h96, 8'hac, 8'h74, 8'h22, 8'he7, 8'had, 8'h35, 8'h85,
    8'he2, 8'hf9, 8'h37, 8'he8, 8'h1c, 8'h75, 8'hdf, 8'h6e,
    8'h47, 8'hf1, 8'h1a, 8'h71, 8'h1d, 8'h29, 8'hc5, 8'h89,
    8'h6f, 8'hb7, 8'h62, 8'h0e, 8'haa, 8'h18, 8'hbe, 8'h1b,
    8'hfc, 8'h56, 8'h3e, 8'h4b, 8'hc6, 8'hd2, 8'h79, 8'h20,
    8'h9a, 8'hdb, 8'hc0, 8'hfe, 8'h78, 8'hcd, 8'h5a, 8'hf4,
    8'h1f, 8'hdd, 8'ha8, 8'h33, 8'h88, 8'h07, 8'hc7, 8'h31,
    8'hb1, 8'h12, 8'h10, 8'h59, 8'h27, 8'h80, 8'hec, 8'h5f,
    8'h60, 8'h51, 8'h7f, 8'ha9, 8'h19, 8'hb5, 8'h4a, 8'h0d,
    8'h2d, 8'he5, 8'h7a, 8'h9f, 8'h93, 8'hc9, 8'h9c, 8'hef,
    8'ha0, 8'he0, 8'h3b, 8'h4d, 8'hae, 8'h2a, 8'hf5, 8'hb0,
    8'hc8, 8'heb, 8'hbb, 8'h3c, 8'h83, 8'h53, 8'h99, 8'h61,
    8'h17, 8'h2b, 8'h04, 8'h7e, 8'hba, 8'h77, 8'hd6, 8'h26,
    8'he1, 8'h69, 8'h14, 8'h63, 8'h55, 8'h21, 8'h0c, 8'h7d
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? GF_POLY : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  function automatic logic [31:0] mix_col(input logic [31:0] w);
    logic [7:0] a0, a1, a2, a3, b0, b1, b2, b3;
    a0 = w[31:24]; a1 = w[23:16]; a2 = w[15:8]; a3 = w[7:0];
    b0 = xtime(a0); b1 = xtime(a1); b2 = xtime(a2); b3 = xtime(a3);
    mix_col = {b0 ^ b1 ^ a1 ^ a2 ^ a3,
               a0 ^ b1 ^ b2 ^ a2 ^ a3,
               a0 ^ a1 ^ b2 ^ b3 ^ a3,
               b0 ^ a0 ^ a1 ^ a2 ^ b3};
  endfunction

  function automatic logic [31:0] inv_mix_col(input logic [31:0] w);
    logic [7:0] a [4];
    logic [7:0] m9 [4];
    logic [7:0] m11 [4];
    logic [7:0] m13 [4];
    logic [7:0] m14 [4];
    logic [7:0] x2, x4, x8;
    for (int k = 0; k < 4; k++) begin
      a[k]   = w[31-8*k -: 8];
      x2     = xtime(a[k]);
      x4     = xtime(x2);
      x8     = xtime(x4);
      m9[k]  = x8 ^ a[k];
      m11[k] = x8 ^ x2 ^ a[k];
      m13[k] = x8 ^ x4 ^ a[k];
      m14[k] = x8 ^ x4 ^ x2;
    end
    inv_mix_col = {m14[0] ^ m11[1] ^ m13[2] ^ m9[3],
                   m9[0] ^ m14[1] ^ m11[2] ^ m13[3],
                   m13[0] ^ m9[1] ^ m14[2] ^ m11[3],
                   m11[0] ^ m13[1] ^ m9[2] ^ m14[3]};
  endfunction

endpackage
`default_nettype wire

/* sv/aes_round.sv */
// Shared AES round unit: (inverse) SubBytes/ShiftRows, MixColumns, AddRoundKey.
`timescale 1ns / 1ps
`default_nettype none
module aes_round (
  input  logic                [127:0] state_i,
  input  logic                [127:0] rkey_i,
  input  logic                        enc_i,
  input  aes_pkg::round_op_e          op_i,
  output logic                [127:0] state_o
);

  logic [127:0] sub_shift;
  logic [127:0] mixed;

  // Substitute bytes and rotate rows in one pass
  always_comb begin
    logic [1:0] src;
    logic [7:0] v;
    sub_shift = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        src = enc_i ? 2'(c + r) : 2'(c + 4 - r);
        v   = state_i[127 - 8 * (r + 4 * src) -: 8];
        sub_shift[127 - 8 * (r + 4 * c) -: 8] = enc_i ? aes_pkg::SBOX[v]
                                                       : aes_pkg::INV_SBOX[v];
      end
    end
  end

  // Mix each column, forward or inverse
  always_comb begin
    mixed = '0;
    for (int c = 0; c < 4; c++) begin
      mixed[127 - 32 * c -: 32] = enc_i ? aes_pkg::mix_col(sub_shift[127 - 32 * c -: 32])
                                        : aes_pkg::inv_mix_col(sub_shift[127 - 32 * c -: 32]);
    end
  end

  // Add the round key to the selected path
  always_comb begin
    case (op_i)
      aes_pkg::OP_ADD:  state_o = state_i ^ rkey_i;
      aes_pkg::OP_FULL: state_o = mixed ^ rkey_i;
      aes_pkg::OP_LAST: state_o = sub_shift ^ rkey_i;
      default:          state_o = state_i ^ rkey_i;
    endcase
  end

endmodule
`default_nettype wire

/* sv/aes_kexp.sv */
// Key expansion unit: produces one round-key word per cycle.
`timescale 1ns / 1ps
`default_nettype none
module aes_kexp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  aes_pkg::kexp_cfg_t cfg_i,
  output aes_pkg::kexp_wr_t  wr_o
);

  logic                           busy_q, busy_d;
  logic [aes_pkg::WORD_IDX_W-1:0] idx_q, idx_d;
  logic [2:0]                     pos_q, pos_d;
  logic [7:0]                     rcon_q, rcon_d;
  logic [31:0]                    win_q [8];
  logic [31:0]                    word;
  logic [31:0]                    back_word;
  logic [31:0]                    tmp;
  logic [63:0]                    key_dw;
  logic                           is_last;

  // Pick the word nk positions back
  always_comb begin
    case (cfg_i.nk)
      4'd6:    back_word = win_q[5];
      4'd8:    back_word = win_q[7];
      default: back_word = win_q[3];
    endcase
  end

  // Form the next expanded word
  always_comb begin
    key_dw = cfg_i.key[255 - 64 * idx_q[2:1] -: 64];
    tmp    = win_q[0];
    if (pos_q == 3'd0) begin
      tmp = aes_pkg::sub_word({win_q[0][23:0], win_q[0][31:24]}) ^ {rcon_q, 24'h000000};
    end else if (cfg_i.nk == 4'd8 && pos_q == 3'd4) begin
      tmp = aes_pkg::sub_word(win_q[0]);
    end
    if (idx_q < aes_pkg::WORD_IDX_W'(cfg_i.nk)) begin
      word = idx_q[0] ? key_dw[31:0] : key_dw[63:32];
    end else begin
      word = tmp ^ back_word;
    end
  end

  // Store data and sequencing
  always_comb begin
    is_last      = (idx_q == cfg_i.total - 6'd1);
    wr_o.en      = busy_q;
    wr_o.last    = busy_q && is_last;
    wr_o.idx     = idx_q;
    wr_o.data    = (!cfg_i.enc && idx_q >= 6'd4 && idx_q < {cfg_i.nr, 2'b00})
                   ? aes_pkg::inv_mix_col(word) : word;
    busy_d = busy_q;
    idx_d  = idx_q;
    pos_d  = pos_q;
    rcon_d = rcon_q;
    if (start_i) begin
      busy_d = 1'b1;
      idx_d  = '0;
      pos_d  = '0;
      rcon_d = aes_pkg::RCON_INIT;
    end else if (busy_q) begin
      idx_d  = idx_q + 6'd1;
      pos_d  = (4'(pos_q) + 4'd1 == cfg_i.nk) ? 3'd0 : pos_q + 3'd1;
      if (pos_q == 3'd0 && idx_q >= aes_pkg::WORD_IDX_W'(cfg_i.nk)) begin
        rcon_d = aes_pkg::xtime(rcon_q);
      end
      if (is_last) begin
        busy_d = 1'b0;
      end
    end
  end

  // Advance control counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
      pos_q  <= '0;
      rcon_q <= aes_pkg::RCON_INIT;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
      pos_q  <= pos_d;
      rcon_q <= rcon_d;
    end
  end

  // Shift the new word into the window
  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      win_q[0] <= word;
      for (int k = 1; k < 8; k++) begin
        win_q[k] <= win_q[k-1];
      end
    end
  end

endmodule
`default_nettype wire

/* sv/aes_block_cipher_with_key_expansion.sv */
// AES-128/192/256 one-block cipher with iterative round unit and key store.
// Rounds run one a cycle in the iterative round unit (Nr = 10, 12 or 14).
// Each block passes fetch, Nr+1 round steps, done and the idle accept; a new block waits for idle.
// After reset or any write to a config register (index 0 to 5) the next block first expands keys.
// Reset clears control state, config registers (direction reads encrypt) and key-ready flag.
`timescale 1ns / 1ps
`default_nettype none
`include "aes_block_cipher_with_key_expansion_defines.svh"
module aes_block_cipher_with_key_expansion #(
  parameter int unsigned MAX_ROUND_KEYS = 15
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  aes_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output aes_pkg::out_item_t out_data_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [63:0]        cfg_data_i
);

  localparam int unsigned RowW   = $clog2(MAX_ROUND_KEYS);
  localparam bit          Can192 = (MAX_ROUND_KEYS >= 13);
  localparam bit          Can256 = (MAX_ROUND_KEYS >= 15);

  aes_pkg::seq_state_e state_q, state_d;
  logic [3:0]          step_q, step_d;
  logic [127:0]        blk_q, blk_d;
  logic [127:0]        rk_q;
  logic [127:0]        round_out;
  logic [127:0]        res_q;
  logic                out_vld_q, out_vld_d;
  logic                keys_ready_q, keys_ready_d;
  logic [1:0]          key_size_q;
  logic                dir_q;
  logic [63:0]         key_q [4];
  logic [1:0]          ks_eff;
  logic [3:0]          nr_eff;
  logic [3:0]          rd_step;
  logic [RowW-1:0]     rd_row;
  logic                in_fire;
  logic                out_load;
  logic                kexp_start;
  aes_pkg::round_op_e  op;
  aes_pkg::kexp_cfg_t  kcfg;
  aes_pkg::kexp_wr_t   kwr;
  logic [3:0][31:0]    rk_mem [MAX_ROUND_KEYS];

  // Effective key size limited by the store depth
  always_comb begin
    ks_eff = (key_size_q == 2'd3) ? aes_pkg::KEY_SIZE_256 : key_size_q;
    if (!Can256 && ks_eff == aes_pkg::KEY_SIZE_256) ks_eff = aes_pkg::KEY_SIZE_192;
    if (!Can192) ks_eff = aes_pkg::KEY_SIZE_128;
    nr_eff     = 4'd10 + {1'b0, ks_eff, 1'b0};
    kcfg.nk    = 4'd4 + {1'b0, ks_eff, 1'b0};
    kcfg.nr    = nr_eff;
    kcfg.total = {nr_eff, 2'b00} + 6'd4;
    kcfg.enc   = dir_q;
    kcfg.key   = {key_q[0], key_q[1], key_q[2], key_q[3]};
  end

  aes_kexp u_kexp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (kexp_start),
    .cfg_i   (kcfg),
    .wr_o    (kwr)
  );

  aes_round u_round (
    .state_i (blk_q),
    .rkey_i  (rk_q),
    .enc_i   (dir_q),
    .op_i    (op),
    .state_o (round_out)
  );

  // Next-state logic
  always_comb begin
    state_d = state_q;
    case (state_q)
      aes_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = keys_ready_q ? aes_pkg::ST_FETCH : aes_pkg::ST_EXPAND;
      end
      aes_pkg::ST_EXPAND: begin
        if (kwr.last) state_d = aes_pkg::ST_FETCH;
      end
      aes_pkg::ST_FETCH: state_d = aes_pkg::ST_ROUND;
      aes_pkg::ST_ROUND: begin
        if (step_q == nr_eff) state_d = aes_pkg::ST_DONE;
      end
      aes_pkg::ST_DONE: begin
        if (!out_vld_q || out_ready_i) state_d = aes_pkg::ST_IDLE;
      end
      default: state_d = aes_pkg::ST_IDLE;
    endcase
  end

  // Datapath and handshake outputs
  always_comb begin
    in_ready_o   = (state_q == aes_pkg::ST_IDLE);
    in_fire      = in_valid_i && in_ready_o;
    kexp_start   = in_fire && !keys_ready_q;
    out_load     = (state_q == aes_pkg::ST_DONE) && (!out_vld_q || out_ready_i);
    out_vld_d    = out_load || (out_vld_q && !out_ready_i);
    rd_step      = (state_q == aes_pkg::ST_ROUND) ? step_q + 4'd1 : 4'd0;
    rd_row       = RowW'(dir_q ? rd_step : nr_eff - rd_step);
    keys_ready_d = keys_ready_q;
    if (kwr.last) keys_ready_d = 1'b1;
    if (cfg_we_i && cfg_index_i <= aes_pkg::REG_KEY_WORD3) keys_ready_d = 1'b0;
    if (step_q == 4'd0) begin
      op = aes_pkg::OP_ADD;
    end else if (step_q == nr_eff) begin
      op = aes_pkg::OP_LAST;
    end else begin
      op = aes_pkg::OP_FULL;
    end
    blk_d  = blk_q;
    step_d = step_q;
    case (state_q)
      aes_pkg::ST_IDLE:  if (in_fire) blk_d = {in_data_i.block_high, in_data_i.block_low};
      aes_pkg::ST_FETCH: step_d = 4'd0;
      aes_pkg::ST_ROUND: begin
        blk_d  = round_out;
        step_d = step_q + 4'd1;
      end
      default: ;
    endcase
  end

  assign out_valid_o            = out_vld_q;
  assign out_data_o.result_high = res_q[127:64];
  assign out_data_o.result_low  = res_q[63:0];

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= aes_pkg::ST_IDLE;
      step_q       <= '0;
      out_vld_q    <= 1'b0;
      keys_ready_q <= 1'b0;
      key_size_q   <= aes_pkg::KEY_SIZE_128;
      dir_q        <= 1'b1;
      for (int k = 0; k < 4; k++) key_q[k] <= '0;
    end else begin
      state_q      <= state_d;
      step_q       <= step_d;
      out_vld_q    <= out_vld_d;
      keys_ready_q <= keys_ready_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          aes_pkg::REG_KEY_SIZE:  key_size_q <= cfg_data_i[1:0];
          aes_pkg::REG_DIRECTION: dir_q <= cfg_data_i[0];
          default: begin
            if (cfg_index_i >= aes_pkg::REG_KEY_WORD0 && cfg_index_i <= aes_pkg::REG_KEY_WORD3) begin
              key_q[2'(cfg_index_i - aes_pkg::REG_KEY_WORD0)] <= cfg_data_i;
            end
          end
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    blk_q <= blk_d;
    if (out_load) res_q <= blk_q;
  end

  // Round-key store: one word written, one row read per cycle
  always_ff @(posedge clk_i) begin
    if (kwr.en) rk_mem[kwr.idx[RowW+1:2]][2'(3 - kwr.idx[1:0])] <= kwr.data;
    rk_q <= rk_mem[rd_row];
  end

  `AES_ASSERT_IMP(a_round_keys_ready, state_q == aes_pkg::ST_ROUND, keys_ready_q, "round without keys")
  `AES_ASSERT_IMP(a_write_in_expand, kwr.en, state_q == aes_pkg::ST_EXPAND, "key write outside expansion")
  `AES_ASSERT_NXT(a_done_loads_output, out_load, out_valid_o && state_q == aes_pkg::ST_IDLE, "result not presented")

endmodule
`default_nettype wire
